// ----- design/ahfr_pkg.sv -----
// Shared types, constants and the hex digit decoder for the ASCII hex frame receiver.
package ahfr_pkg;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_IDLE = 1'b1;
	localparam logic [15:0] TIMEOUT_RESET = 16'd100;
	localparam logic REG_TIMEOUT = 1'b0;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_char;
	} in_item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic [4:0] byte_index;
		logic [5:0] frame_length;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic wr_en;
		logic start;
	} buf_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD
	} emit_state_t;

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [3:0] nib;
		case (c) inside
			[8'h30:8'h39]: nib = c[3:0];
			[8'h41:8'h46], [8'h61:8'h66]: nib = c[3:0] + 4'd9;
			default: nib = 4'd0;
		endcase
		return nib;
	endfunction

endpackage

// ----- design/ascii_hex_frame_receiver.sv -----
// Top level of the ASCII hex frame receiver: character intake, idle timer and config port.
//
// Input channel (in_valid/in_ready/in_data): each transfer is a received character
// (op = OP_CHAR) or an idle tick (op = OP_IDLE). Hex digits are packed two to a
// byte, high nibble first, into the frame memory; a CR closes the frame.
// Output channel (out_valid/out_ready/out_data): one transfer per frame byte, in
// order, with last set on the final byte. Frames with an odd nibble count or no
// bytes produce nothing.
// A closing CR starts emission: for each byte the sequencer first reads the
// frame memory (ST_READ) and then loads the output register (ST_LOAD); input
// is held off (in_ready low) until the last byte is in the output register.
// A stalled receiver holds the current byte in the output register and the
// sequencer waits; the final byte may still be waiting when the next
// character is taken.
// Reset clears the nibble count, idle timer and sequencer and loads
// timeout_ticks with 100. The frame memory is not cleared; only bytes written
// in the current frame are ever emitted.
// APB register at byte address 0: timeout_ticks (bits 15:0).
module ascii_hex_frame_receiver #(
	parameter int MAX_FRAME_BYTES = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ahfr_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ahfr_pkg::out_item_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import ahfr_pkg::*;

	localparam int AW = $clog2(MAX_FRAME_BYTES);
	localparam int LW = $clog2(MAX_FRAME_BYTES + 1);
	localparam int CW = $clog2(2 * MAX_FRAME_BYTES + 1);
	localparam logic [CW-1:0] COUNT_MAX = CW'(2 * MAX_FRAME_BYTES);

	logic [15:0] timeout_q;
	logic [15:0] idle_left_q;
	logic [CW-1:0] count_q;
	logic [3:0] hi_nib_q;
	logic [3:0] nib;
	logic in_fire;
	logic is_char;
	logic is_cr;
	logic busy;
	buf_ctrl_t ctrl;
	logic [AW-1:0] wr_addr;
	logic [7:0] wr_data;
	logic [LW-1:0] len;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'd0, timeout_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			timeout_q <= TIMEOUT_RESET;
		else if (psel && penable && pwrite && paddr[2] == REG_TIMEOUT)
			timeout_q <= pwdata[15:0];
	end

	assign in_ready = !busy;
	assign in_fire = in_valid && in_ready;
	assign is_char = in_data.op == OP_CHAR;
	assign is_cr = in_data.rx_char == CHAR_CR;
	assign nib = hex_nibble(in_data.rx_char);

	// odd count means the high nibble sits in hi_nib_q: write the whole byte
	assign ctrl.wr_en = in_fire && is_char && !is_cr && count_q[0];
	assign ctrl.start = in_fire && is_char && is_cr && !count_q[0] && count_q != '0;
	assign wr_addr = AW'(count_q >> 1);
	assign wr_data = {hi_nib_q, nib};
	assign len = LW'(count_q >> 1);

	always_ff @(posedge clk) begin
		if (in_fire && is_char && !is_cr && !count_q[0])
			hi_nib_q <= nib;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idle_left_q <= '0;
		end else if (in_fire) begin
			if (is_char) begin
				idle_left_q <= timeout_q;
				if (is_cr || count_q == COUNT_MAX)
					count_q <= '0;
				else
					count_q <= count_q + CW'(1);
			end else if (idle_left_q != '0) begin
				idle_left_q <= idle_left_q - 16'd1;
			end else begin
				// drop the partial frame
				count_q <= '0;
			end
		end
	end

	ahfr_frame_buf #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_frame_buf (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.len(len),
		.busy(busy),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_MAX)
		else $error("nibble count beyond frame capacity");

	a_start_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |=> !in_ready)
		else $error("input taken while a frame is being emitted");

	a_midframe_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> !in_ready)
		else $error("input open before the last byte was loaded");

	a_no_write_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !ctrl.wr_en && !ctrl.start)
		else $error("frame memory touched during emission");
`endif

endmodule

// ----- design/ahfr_frame_buf.sv -----
// Frame byte memory with the emission sequencer and the output register.
module ahfr_frame_buf #(
	parameter int MAX_FRAME_BYTES = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ahfr_pkg::buf_ctrl_t          ctrl,
	input  logic [$clog2(MAX_FRAME_BYTES)-1:0]   wr_addr,
	input  logic [7:0]                   wr_data,
	input  logic [$clog2(MAX_FRAME_BYTES+1)-1:0] len,
	output logic                         busy,
	output logic                         out_valid,
	input  logic                         out_ready,
	output ahfr_pkg::out_item_t          out_data
);
	import ahfr_pkg::*;

	localparam int AW = $clog2(MAX_FRAME_BYTES);
	localparam int LW = $clog2(MAX_FRAME_BYTES + 1);

	logic [7:0] mem [MAX_FRAME_BYTES];
	logic [7:0] rd_data_q;
	emit_state_t state_q, state_nxt;
	logic [AW-1:0] k_q;
	logic [LW-1:0] len_q;
	logic out_valid_q;
	out_item_t out_data_q;
	logic load;
	logic is_last;

	assign is_last = (LW'(k_q) + LW'(1)) == len_q;
	assign busy = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en)
			mem[wr_addr] <= wr_data;
		rd_data_q <= mem[k_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (ctrl.start)
					state_nxt = ST_READ;
			end
			ST_READ: state_nxt = ST_LOAD;
			ST_LOAD: begin
				// hold the byte until the output register frees up
				if (!out_valid_q || out_ready) begin
					load = 1'b1;
					state_nxt = is_last ? ST_IDLE : ST_READ;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			k_q <= '0;
			len_q <= '0;
		end else begin
			if (ctrl.start) begin
				k_q <= '0;
				len_q <= len;
			end else if (load) begin
				k_q <= k_q + AW'(1);
			end
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q.frame_byte <= rd_data_q;
			out_data_q.byte_index <= 5'(k_q);
			out_data_q.frame_length <= 6'(len_q);
			out_data_q.last <= is_last;
		end
	end

endmodule

// ----- tb/sv/ascii_hex_frame_receiver_tb.sv -----
// Self-checking testbench for the ASCII hex frame receiver: stimulus, deframer tracking, checks.
module ascii_hex_frame_receiver_tb;
	import ahfr_pkg::*;

	localparam int MAX_BYTES = 32;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [2:0] ADDR_TIMEOUT = 3'(4 * REG_TIMEOUT);
	localparam logic [2:0] ADDR_SPARE = 3'd4;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	// tracked deframer state
	logic [6:0] nib_cnt;
	logic [15:0] idle_ticks_left;
	logic [15:0] timeout_reg;
	logic [7:0] frame_mem [MAX_BYTES];
	out_item_t frame_bytes_due [$];

	bit failed = 1'b0;
	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;
	int burst_left = 0;
	int hold_len = 0;
	int items_sent = 0;

	ascii_hex_frame_receiver #(.MAX_FRAME_BYTES(MAX_BYTES)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [3:0] digit_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") return 4'(c - "0");
		if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
		if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
		return 4'd0;
	endfunction

	function automatic logic [7:0] rand_hex_char();
		logic [3:0] d;
		d = 4'($urandom);
		if (d < 10) return 8'("0" + d);
		return 8'(($urandom_range(1) ? "a" : "A") + d - 10);
	endfunction

	// Advance the tracked state by one accepted transfer; queue any frame bytes it releases.
	function automatic void deframe_step(input logic op, input logic [7:0] ch);
		out_item_t b;
		int len;
		if (op == OP_CHAR) begin
			if (ch != CHAR_CR) begin
				if (nib_cnt < 2 * MAX_BYTES) begin
					if (!nib_cnt[0])
						frame_mem[nib_cnt[5:1]] = {digit_value(ch), 4'h0};
					else
						frame_mem[nib_cnt[5:1]][3:0] = digit_value(ch);
				end
				// one nibble past a full frame wraps the count
				nib_cnt = (nib_cnt == 2 * MAX_BYTES) ? '0 : nib_cnt + 7'd1;
			end else begin
				if (!nib_cnt[0] && nib_cnt != 0) begin
					len = int'(nib_cnt >> 1);
					for (int k = 0; k < len; k++) begin
						b.frame_byte = frame_mem[k];
						b.byte_index = k[4:0];
						b.frame_length = len[5:0];
						b.last = (k == len - 1);
						frame_bytes_due.push_back(b);
					end
				end
				nib_cnt = '0;
			end
			idle_ticks_left = timeout_reg;
		end else if (idle_ticks_left != 0) begin
			idle_ticks_left = idle_ticks_left - 16'd1;
		end else begin
			nib_cnt = '0;
		end
	endfunction

	task automatic send_item(input logic op, input logic [7:0] ch);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			burst_left = $urandom_range(1, 16);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		if (burst_left > 0) burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= '{op: op, rx_char: ch};
		do @(posedge clk); while (!in_ready);
		deframe_step(op, ch);
		items_sent++;
	endtask

	task automatic send_tick();
		send_item(OP_IDLE, 8'($urandom));
	endtask

	task automatic end_frame();
		send_item(OP_CHAR, CHAR_CR);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_item(OP_CHAR, s[i]);
	endtask

	task automatic send_frame(input int nbytes, input bit with_ticks);
		for (int i = 0; i < 2 * nbytes; i++) begin
			if (with_ticks && $urandom_range(3) == 0) repeat ($urandom_range(1, 3)) send_tick();
			send_item(OP_CHAR, rand_hex_char());
		end
		end_frame();
	endtask

	// Drop valid and let every pending frame byte drain before touching config.
	task automatic wait_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
		while (frame_bytes_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register, then read timeout_ticks back.
	task automatic set_timeout(input logic [2:0] addr, input logic [15:0] ticks);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {16'($urandom), ticks};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_TIMEOUT) timeout_reg = ticks;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= ADDR_TIMEOUT;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[15:0] !== timeout_reg) begin
			$error("timeout_ticks: expected %0d, got %0d", timeout_reg, prdata[15:0]);
			failed = 1'b1;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_decode_range();
		send_text("09AFaf/:@G`g");
		send_item(OP_CHAR, 8'h00);
		send_item(OP_CHAR, 8'hFF);
		send_item(OP_CHAR, 8'h0C);
		send_item(OP_CHAR, 8'h0E);
		end_frame();
	endtask

	task automatic test_odd_and_empty();
		send_text("123");
		end_frame();
		end_frame();
		// an idle tick carrying CR must not close anything
		send_text("4");
		send_item(OP_IDLE, CHAR_CR);
		send_text("5");
		end_frame();
	endtask

	task automatic test_idle_timeout();
		wait_quiet();
		set_timeout(ADDR_TIMEOUT, 16'd2);
		send_text("1");
		repeat (2) send_tick();
		send_text("2");
		end_frame();
		send_text("3");
		repeat (3) send_tick();
		send_text("45");
		end_frame();
		wait_quiet();
		set_timeout(ADDR_TIMEOUT, 16'd0);
		send_text("6");
		send_tick();
		send_text("78");
		end_frame();
		// tick with the timer already at zero right after a frame
		send_tick();
		send_text("9a");
		end_frame();
		wait_quiet();
		set_timeout(ADDR_TIMEOUT, 16'hFFFF);
		send_text("9A");
		repeat (5) send_tick();
		send_text("bc");
		end_frame();
		wait_quiet();
		set_timeout(ADDR_SPARE, 16'($urandom));
	endtask

	task automatic test_full_and_overflow();
		send_frame(MAX_BYTES, 1'b0);
		repeat (2 * MAX_BYTES + 1) send_item(OP_CHAR, rand_hex_char());
		send_text("dE");
		end_frame();
	endtask

	task automatic test_backpressure();
		wait_quiet();
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		hold_len = 400;
		repeat (2) send_frame(16, 1'b0);
		wait (hold_len == 0);
		wait_quiet();
	endtask

	task automatic test_random_traffic(input logic [15:0] ticks, input bit idling, input int count);
		int stop_at;
		int pick;
		wait_quiet();
		set_timeout(ADDR_TIMEOUT, ticks);
		gaps_on = idling;
		stalls_on = idling;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				send_frame(($urandom_range(9) == 0) ? $urandom_range(1, MAX_BYTES)
					: $urandom_range(1, 6), 1'b1);
			end else if (pick < 80) begin
				repeat ($urandom_range(0, 9)) send_item(OP_CHAR, 8'($urandom));
				end_frame();
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 10)) send_tick();
			end else begin
				send_item(1'($urandom), 8'($urandom));
			end
		end
	endtask

	// Receiver: rotate a random ready pattern, or hold ready low on a hold_len request.
	initial begin : sink
		logic [15:0] pattern;
		int cyc;
		out_ready = 1'b0;
		pattern = '1;
		cyc = 0;
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				out_ready <= 1'b0;
				repeat (hold_len) @(negedge clk);
				hold_len = 0;
			end
			if (cyc % 48 == 0) pattern = stalls_on ? 16'($urandom) : '1;
			out_ready <= pattern[0];
			pattern = {pattern[0], pattern[15:1]};
			cyc++;
		end
	end

	always @(posedge clk) begin : check_out
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (frame_bytes_due.size() == 0) begin
				$error("frame_byte %02h arrived with nothing pending", out_data.frame_byte);
				failed = 1'b1;
			end else begin
				want = frame_bytes_due.pop_front();
				if (out_data.frame_byte !== want.frame_byte) begin
					$error("frame_byte: expected %02h, got %02h",
						want.frame_byte, out_data.frame_byte);
					failed = 1'b1;
				end
				if (out_data.byte_index !== want.byte_index) begin
					$error("byte_index: expected %0d, got %0d",
						want.byte_index, out_data.byte_index);
					failed = 1'b1;
				end
				if (out_data.frame_length !== want.frame_length) begin
					$error("frame_length: expected %0d, got %0d",
						want.frame_length, out_data.frame_length);
					failed = 1'b1;
				end
				if (out_data.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, out_data.last);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		#1000000;
		$display("ascii_hex_frame_receiver test failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		nib_cnt = '0;
		idle_ticks_left = '0;
		timeout_reg = TIMEOUT_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_decode_range();
		test_odd_and_empty();
		test_idle_timeout();
		test_full_and_overflow();
		test_backpressure();
		test_random_traffic(16'd1, 1'b1, 16);
		test_random_traffic(16'd7, 1'b1, 16);
		test_random_traffic(16'd0, 1'b0, 16);
		test_random_traffic(16'hFFFF, 1'b1, 16);
		test_random_traffic(16'($urandom_range(2, 300)), 1'b1, 16);
		test_random_traffic(TIMEOUT_RESET, 1'b1, 16);
		wait_quiet();

		if (!failed) begin
			$display("ascii_hex_frame_receiver test passed");
		end else begin
			$display("ascii_hex_frame_receiver test failed");
		end
		$finish;
	end

endmodule
